@@ src/pmn_pkg.sv @@
// Shared types and constants of the plane mean normalizer.
`default_nettype none

package pmn_pkg;

  localparam int unsigned REG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned PROD_W    = 16;
  localparam int unsigned DEN_W     = SUM_W + 2;
  localparam int unsigned QUOT_W    = PIX_W + 1;

  localparam logic [REG_W-1:0] WIDTH_RESET  = REG_W'(640);
  localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(480);

  // 0.15 * 255 * 4 = 153, the 4 goes into the divisor
  localparam logic [PIX_W-1:0] SCALE_MUL = PIX_W'(153);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_SCALE   = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel;
  } pmn_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] scaled_pixel;
    logic             plane_end;
    logic             zero_mean;
  } pmn_out_t;

  typedef struct packed {
    logic load;
    logic meas;
    logic capture;
    logic div_start;
    logic commit;
  } pmn_cmd_t;

  typedef struct packed {
    logic div_last;
  } pmn_sts_t;

endpackage

`default_nettype wire

@@ src/pmn_div.sv @@
// Restoring divider, one quotient bit per cycle, top bit flags saturation.
`default_nettype none

module pmn_div import pmn_pkg::*; #(
  parameter int unsigned NUM_W = 42
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              last_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int unsigned SH_W  = DEN_W + QUOT_W - 1;
  localparam int unsigned W     = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int unsigned CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [W-1:0]      rem_q, rem_d;
  logic [W-1:0]      dvs_q, dvs_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic              ge;

  assign ge = (rem_q >= dvs_q);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = W'(num_i);
      dvs_d  = W'(den_i) << (QUOT_W - 1);
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (rem_q - dvs_q) : rem_q;
      dvs_d  = dvs_q >> 1;
      quot_d = {quot_q[QUOT_W-2:0], ge};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign last_o = busy_q && (cnt_q == CNT_LAST);
  assign quot_o = quot_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_full_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(cnt_q) == CNT_LAST)
    else $error("divider stopped before the last quotient bit");

endmodule

`default_nettype wire

@@ src/pmn_ctrl.sv @@
// Sequencer of the plane mean normalizer: request intake, steps, output slot.
`default_nettype none

module pmn_ctrl import pmn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  pmn_sts_t sts_i,
  output pmn_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MEAS = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_load;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_op_i == OP_SCALE) ? S_MUL1 : S_MEAS;
        end
      end
      S_MEAS: begin
        cmd_o.meas = 1'b1;
        state_d    = S_IDLE;
      end
      S_MUL1: begin
        cmd_o.capture = 1'b1;
        state_d       = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output slot is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_load     = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("loaded result not presented");

  a_rise_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result appeared outside the output step");

endmodule

`default_nettype wire

@@ src/pmn_dp.sv @@
// Datapath: registers, plane size, running sum, position, scaling and divider.
`default_nettype none

module pmn_dp import pmn_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  pmn_in_t              in_data_i,
  input  pmn_cmd_t             cmd_i,
  output pmn_sts_t             sts_o,
  output pmn_out_t             out_data_o
);

  localparam int unsigned SIDE_BITS = $clog2(MAX_SIDE + 1);
  localparam int unsigned SIDE_W    = (SIDE_BITS < REG_W) ? SIDE_BITS : REG_W;
  localparam int unsigned N_W       = 2 * SIDE_W;
  localparam int unsigned CMP_W     = (N_W > POS_W + 1) ? N_W : POS_W + 1;
  localparam int unsigned NUM_W     = PROD_W + N_W;

  logic [REG_W-1:0]  width_q, height_q;
  logic [SIDE_W-1:0] w_side, h_side;
  logic [N_W-1:0]    n_q;
  logic [PIX_W-1:0]  px_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [PROD_W-1:0] prod_q;
  logic [DEN_W-1:0]  den_q;
  logic              zero_q;
  pmn_out_t          out_q, out_d;

  logic [POS_W:0]    pos_inc;
  logic              last;
  logic [POS_W-1:0]  pos_next;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic [NUM_W-1:0]  num;
  logic              div_last;
  logic [QUOT_W-1:0] quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end else if (cfg_index_i == REG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // zero reads as one, anything past the limit as the limit
  always_comb begin
    if (width_q == '0) begin
      w_side = SIDE_W'(1);
    end else if (32'(width_q) > MAX_SIDE) begin
      w_side = SIDE_W'(MAX_SIDE);
    end else begin
      w_side = SIDE_W'(width_q);
    end
    if (height_q == '0) begin
      h_side = SIDE_W'(1);
    end else if (32'(height_q) > MAX_SIDE) begin
      h_side = SIDE_W'(MAX_SIDE);
    end else begin
      h_side = SIDE_W'(height_q);
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= N_W'(w_side) * N_W'(h_side);
  end

  assign pos_inc  = {1'b0, pos_q} + (POS_W + 1)'(1);
  assign last     = CMP_W'(pos_inc) >= CMP_W'(n_q);
  assign pos_next = last ? '0 : pos_inc[POS_W-1:0];
  assign sum_add  = {1'b0, sum_q} + (SUM_W + 1)'(px_q);
  assign sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  always_comb begin
    sum_d = sum_q;
    pos_d = pos_q;
    if (cmd_i.meas) begin
      sum_d = sum_sat;
      pos_d = pos_next;
    end else if (cmd_i.commit) begin
      pos_d = pos_next;
      if (last) begin
        sum_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      pos_q <= '0;
    end else begin
      sum_q <= sum_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= in_data_i.pixel;
    end
    if (cmd_i.capture) begin
      prod_q <= PROD_W'(px_q) * PROD_W'(SCALE_MUL);
      den_q  <= {sum_q, 2'b00};
      zero_q <= (sum_q == '0);
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign num = NUM_W'(prod_q) * NUM_W'(n_q);

  pmn_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den_q),
    .last_o  (div_last),
    .quot_o  (quot)
  );

  always_comb begin
    out_d.plane_end = last;
    out_d.zero_mean = zero_q;
    if (zero_q) begin
      out_d.scaled_pixel = '0;
    end else if (quot[QUOT_W-1]) begin
      out_d.scaled_pixel = '1;
    end else begin
      out_d.scaled_pixel = quot[PIX_W-1:0];
    end
  end

  assign sts_o.div_last = div_last;
  assign out_data_o     = out_q;

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && last) |=> (sum_q == '0) && (pos_q == '0))
    else $error("plane end did not clear sum and position");

endmodule

`default_nettype wire

@@ src/plane_mean_normalizer.sv @@
// Plane mean normalizer: top level joining sequencer and datapath.
//
// Streams one 8-bit plane twice. Measure requests (operation 0) add their
// pixel to a saturating 32-bit sum and give no result. Scale requests
// (operation 1) give min(255, floor(pixel*153*N/(4*sum))), N = width *
// height, with plane_end on the last pixel and zero_mean (and a zero
// pixel) when the sum is zero; they pass through intake, two multiply
// steps, the one-bit-per-cycle restoring divider and the load of the
// output register, which waits until the output slot is free or drained.
// The output register lets a new request enter while a result waits.
// Width and height read 0 as 1 and clamp above MAX_SIDE; a register write
// applies to requests accepted on the following cycle or later.
`default_nettype none

module plane_mean_normalizer import pmn_pkg::*; #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pmn_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pmn_out_t             out_data_o
);

  pmn_cmd_t cmd;
  pmn_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pmn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.operation),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pmn_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
